// ===== rtl/uvs_pkg.sv =====
// Shared types and constants of the UV sphere strip vertex generator.
package uvs_pkg;

    // Configuration register indexes
    localparam logic CFG_RING_COUNT    = 1'b0;
    localparam logic CFG_SEGMENT_COUNT = 1'b1;

    localparam logic [8:0] RING_COUNT_RST    = 9'd16;
    localparam logic [8:0] SEGMENT_COUNT_RST = 9'd32;

    // Vertex slots of one request, in emission order
    typedef enum logic [1:0] {
        SEQ_STITCH_PREV = 2'd0,
        SEQ_STITCH_NEXT = 2'd1,
        SEQ_UPPER       = 2'd2,
        SEQ_LOWER       = 2'd3
    } t_seq;

    // Pipelined long division: 48-bit dividend, 8 quotient bits per stage
    localparam int DIV_W              = 48;
    localparam int DIV_BITS_PER_STAGE = 8;
    localparam int DIV_STAGES         = DIV_W / DIV_BITS_PER_STAGE;

    typedef struct packed {
        logic [9:0]       rem;
        logic [DIV_W-1:0] nq;   // dividend bits shift out, quotient bits shift in
    } t_div_lane;

    typedef struct packed {
        logic      last;
        logic      inr;
        t_div_lane pl;          // latitude phase
        t_div_lane pg;          // longitude phase
        t_div_lane tu;          // texture u
        t_div_lane tv;          // texture v
    } t_div_set;

    typedef struct packed {
        logic        last;
        logic        inr;
        logic [16:0] tu;
        logic [16:0] tv;
    } t_side;

    // Q2.30 one and Q1.31 half pi
    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
    localparam logic [31:0] HALF_PI_Q31 = 32'd3373259426;

    // Reciprocals for exact floor division of values below 2^31
    localparam logic [31:0] M_DIV9  = 32'(((64'd1 << 35) + 64'd8) / 64'd9);
    localparam logic [31:0] M_DIV21 = 32'(((64'd1 << 36) + 64'd20) / 64'd21);
    localparam logic [31:0] M_DIV5  = 32'(((64'd1 << 34) + 64'd4) / 64'd5);
    localparam logic [31:0] M_DIV3  = 32'(((64'd1 << 33) + 64'd2) / 64'd3);
    localparam logic [31:0] M_DIV7  = 32'(((64'd1 << 34) + 64'd6) / 64'd7);
    localparam logic [31:0] M_DIV15 = 32'(((64'd1 << 35) + 64'd14) / 64'd15);

    // Eight restoring division steps
    function automatic t_div_lane div_step(input t_div_lane l, input logic [8:0] d);
        t_div_lane o;
        o = l;
        for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
            o.rem = {o.rem[8:0], o.nq[DIV_W-1]};
            o.nq  = {o.nq[DIV_W-2:0], 1'b0};
            if (o.rem >= {1'b0, d}) begin
                o.rem   = o.rem - {1'b0, d};
                o.nq[0] = 1'b1;
            end
        end
        return o;
    endfunction

    // Magnitude of a signed Q2.30 value
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

// ===== rtl/uv_sphere_strip_vertex_gen.sv =====
// Top level of the UV sphere triangle-strip vertex generator.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid  / o_in_ready    | i_ring, i_column
//  out     | out       | o_out_valid / i_out_ready   | o_pos_x/y/z, o_tex_u/v, o_in_range,
//          |           |                             | o_last_of_run
//
// One vertex enters the pipeline per cycle while the output is not stalled; a request yields
// 1, 2 or 4 vertices, one per vertex slot handed out by the request register.
// The request register feeds 7 divider stages, 11 sine/cosine stages and 2 output stages.
// Reset clears valid bits and restores the counts.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module uv_sphere_strip_vertex_gen
    import uvs_pkg::*;
#(
    parameter int MAX_RINGS    = 256,
    parameter int MAX_SEGMENTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_ring,
    input  logic [8:0]         i_column,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic               o_in_range,
    output logic               o_last_of_run
);

    localparam int SC_LAT = 11;

    logic [8:0] r_ring_count, r_segment_count;
    logic [8:0] w_rings, w_segs;
    logic       adv;

    // Configuration registers, counts clamped to the maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count    <= RING_COUNT_RST;
            r_segment_count <= SEGMENT_COUNT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_RING_COUNT)    r_ring_count    <= i_cfg_data;
            if (i_cfg_index == CFG_SEGMENT_COUNT) r_segment_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_rings = (32'(r_ring_count) > MAX_RINGS) ? 9'(MAX_RINGS) : r_ring_count;
    assign w_segs  = (32'(r_segment_count) > MAX_SEGMENTS) ? 9'(MAX_SEGMENTS)
                                                           : r_segment_count;

    // Request register: hands out one vertex slot per cycle while the pipeline advances
    logic       r_req_vld, r_req_inr;
    logic [7:0] r_req_ring;
    logic [8:0] r_req_col;
    t_seq       r_req_seq;
    logic       w_acc, w_inr, w_issue_last;
    logic [8:0] w_a, w_j;

    assign w_issue_last = r_req_vld && adv && (r_req_seq == SEQ_LOWER);
    assign o_in_ready   = !r_req_vld || w_issue_last;
    assign w_acc        = i_in_valid && o_in_ready;
    assign w_inr        = (w_rings != 9'd0) && (w_segs != 9'd0)
                       && ({1'b0, i_ring} < w_rings) && (i_column <= w_segs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (w_acc) begin
            r_req_vld <= 1'b1;
        end else if (w_issue_last) begin
            r_req_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req_ring <= i_ring;
            r_req_col  <= i_column;
            r_req_inr  <= w_inr;
            if (!w_inr)
                r_req_seq <= SEQ_LOWER;
            else if (i_ring != 8'd0 && i_column == 9'd0)
                r_req_seq <= SEQ_STITCH_PREV;
            else
                r_req_seq <= SEQ_UPPER;
        end else if (r_req_vld && adv) begin
            r_req_seq <= t_seq'(r_req_seq + 2'd1);
        end
    end

    // Ring fraction numerator and column of the slot being issued
    always_comb begin
        unique case (r_req_seq)
            SEQ_STITCH_PREV: begin w_a = {1'b0, r_req_ring} - 9'd1; w_j = w_segs;    end
            SEQ_STITCH_NEXT: begin w_a = {1'b0, r_req_ring} + 9'd1; w_j = 9'd0;      end
            SEQ_UPPER:       begin w_a = {1'b0, r_req_ring} + 9'd1; w_j = r_req_col; end
            SEQ_LOWER:       begin w_a = {1'b0, r_req_ring};        w_j = r_req_col; end
        endcase
    end

    // Divider pipeline: phases and texture fractions, rounded to nearest
    t_div_set r_dv     [0:DIV_STAGES];
    logic     r_dv_vld [0:DIV_STAGES];
    t_div_set n_dv0;

    always_comb begin
        n_dv0.last   = (r_req_seq == SEQ_LOWER);
        n_dv0.inr    = r_req_inr;
        n_dv0.pl.rem = 10'd0;
        n_dv0.pl.nq  = (48'(w_a) << 31) + 48'(w_rings >> 1);
        n_dv0.pg.rem = 10'd0;
        n_dv0.pg.nq  = (48'(w_j) << 32) + 48'(w_segs >> 1);
        n_dv0.tu.rem = 10'd0;
        n_dv0.tu.nq  = (48'(w_j) << 16) + 48'(w_segs >> 1);
        n_dv0.tv.rem = 10'd0;
        n_dv0.tv.nq  = (48'(w_a) << 16) + 48'(w_rings >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv[0] <= n_dv0;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_dv[k].last <= r_dv[k-1].last;
                r_dv[k].inr  <= r_dv[k-1].inr;
                r_dv[k].pl   <= div_step(r_dv[k-1].pl, w_rings);
                r_dv[k].pg   <= div_step(r_dv[k-1].pg, w_segs);
                r_dv[k].tu   <= div_step(r_dv[k-1].tu, w_segs);
                r_dv[k].tv   <= div_step(r_dv[k-1].tv, w_rings);
            end
        end
    end

    // Sine and cosine of both angles
    logic signed [31:0] w_sl, w_cl, w_sg, w_cg;

    uvs_sincos u_lat (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (r_dv[DIV_STAGES].pl.nq[31:0]),
        .o_sin   (w_sl),
        .o_cos   (w_cl)
    );

    uvs_sincos u_lng (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (r_dv[DIV_STAGES].pg.nq[31:0]),
        .o_sin   (w_sg),
        .o_cos   (w_cg)
    );

    // Side data beside the sine/cosine units
    t_side r_sd     [0:SC_LAT-1];
    logic  r_sd_vld [0:SC_LAT-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd[0].last <= r_dv[DIV_STAGES].last;
            r_sd[0].inr  <= r_dv[DIV_STAGES].inr;
            r_sd[0].tu   <= r_dv[DIV_STAGES].tu.nq[16:0];
            r_sd[0].tv   <= r_dv[DIV_STAGES].tv.nq[16:0];
            for (int k = 1; k < SC_LAT; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    // Position products: x = -cos(g)*zr, z = sin(g)*zr, y = -cos of ring angle
    logic [63:0]        r_px, r_pz;
    logic               r_nx, r_nz, r_p_vld;
    logic signed [15:0] r_py;
    t_side              r_p_sd;
    logic [31:0]        w_mcl, w_msl;
    logic [15:0]        w_ym;

    assign w_mcl = mag32(w_cl);
    assign w_msl = mag32(w_sl);
    assign w_ym  = 16'((w_mcl + 32'h8000) >> 16);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px   <= mag32(w_cg) * w_msl;
            r_pz   <= mag32(w_sg) * w_msl;
            r_nx   <= (!w_cg[31] && w_cg != 32'sd0) ^ w_sl[31];
            r_nz   <= w_sg[31] ^ w_sl[31];
            r_py   <= (!w_cl[31] && w_cl != 32'sd0) ? -w_ym : w_ym;
            r_p_sd <= r_sd[SC_LAT-1];
        end
    end

    // Output register
    logic               r_o_vld, r_o_inr, r_o_last;
    logic signed [15:0] r_ox, r_oy, r_oz;
    logic [16:0]        r_ou, r_ov;
    logic [15:0]        w_xm, w_zm;

    assign adv  = !r_o_vld || i_out_ready;
    assign w_xm = 16'((r_px + 64'h2000_0000_0000) >> 46);
    assign w_zm = 16'((r_pz + 64'h2000_0000_0000) >> 46);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_inr  <= r_p_sd.inr;
            r_o_last <= r_p_sd.last;
            if (r_p_sd.inr) begin
                r_ox <= r_nx ? -w_xm : w_xm;
                r_oy <= r_py;
                r_oz <= r_nz ? -w_zm : w_zm;
                r_ou <= r_p_sd.tu;
                r_ov <= r_p_sd.tv;
            end else begin
                r_ox <= '0;
                r_oy <= '0;
                r_oz <= '0;
                r_ou <= '0;
                r_ov <= '0;
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) r_dv_vld[k] <= 1'b0;
            for (int k = 0; k < SC_LAT; k++)     r_sd_vld[k] <= 1'b0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_dv_vld[0] <= r_req_vld;
            for (int k = 1; k <= DIV_STAGES; k++) r_dv_vld[k] <= r_dv_vld[k-1];
            r_sd_vld[0] <= r_dv_vld[DIV_STAGES];
            for (int k = 1; k < SC_LAT; k++)     r_sd_vld[k] <= r_sd_vld[k-1];
            r_p_vld <= r_sd_vld[SC_LAT-1];
            r_o_vld <= r_p_vld;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_pos_x       = r_ox;
    assign o_pos_y       = r_oy;
    assign o_pos_z       = r_oz;
    assign o_tex_u       = r_ou;
    assign o_tex_v       = r_ov;
    assign o_in_range    = r_o_inr;
    assign o_last_of_run = r_o_last;

endmodule

// ===== rtl/uvs_sincos.sv =====
// Pipelined sine and cosine of a 32-bit turn phase, Q2.30 results.
module uvs_sincos
    import uvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_phase,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    logic [61:0] r_pr;
    logic [1:0]  r_q  [0:9];
    logic        r_sw [0:9];
    logic [31:0] r_x  [1:8];
    logic [31:0] r_x2 [2:6];
    logic [63:0] r_x2p;
    logic [63:0] r_as [2:9];
    logic [63:0] r_ac [2:9];
    logic signed [31:0] r_sin, r_cos;

    logic [29:0] w_r, w_rr;
    logic        w_sw;
    logic [62:0] w_sum;
    logic [31:0] w_x, w_x2;
    logic [31:0] w_ts3, w_tc3, w_ts5, w_tc5, w_ts7, w_tc7, w_ts9;
    logic [31:0] w_sm, w_cm, w_s, w_c;
    logic signed [31:0] n_sin, n_cos;

    // Octant reduction, angle scaling, x^2 and the one-minus terms of the series
    always_comb begin
        w_r   = i_phase[29:0];
        w_sw  = w_r > 30'h2000_0000;
        w_rr  = w_sw ? 30'(31'h4000_0000 - {1'b0, w_r}) : w_r;
        w_sum = {1'b0, r_pr} + 63'h4000_0000;
        w_x   = 32'(w_sum >> 31);
        w_x2  = 32'(r_x2p >> 30);
        w_ts3 = Q30_ONE - 32'(r_as[2] >> 35);
        w_tc3 = Q30_ONE - 32'(r_ac[2] >> 34);
        w_ts5 = Q30_ONE - 32'(r_as[4] >> 36);
        w_tc5 = Q30_ONE - 32'(r_ac[4] >> 35);
        w_ts7 = Q30_ONE - 32'(r_as[6] >> 34);
        w_tc7 = Q30_ONE - 32'(r_ac[6] >> 33);
        w_ts9 = Q30_ONE - 32'(r_as[8] >> 33);
    end

    // Swap for upper octant, then quadrant signs
    always_comb begin
        w_sm = 32'(r_as[9] >> 30);
        w_cm = 32'(r_ac[9]);
        w_s  = r_sw[9] ? w_cm : w_sm;
        w_c  = r_sw[9] ? w_sm : w_cm;
        unique case (r_q[9])
            2'd0: begin n_sin = w_s;  n_cos = w_c;  end
            2'd1: begin n_sin = w_c;  n_cos = -w_s; end
            2'd2: begin n_sin = -w_s; n_cos = -w_c; end
            default: begin n_sin = -w_c; n_cos = w_s; end
        endcase
    end

    // Horner stages: even stages divide by a constant, odd stages multiply by x^2 (the last sine stage by x)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr     <= w_rr * HALF_PI_Q31;
            r_q[0]   <= i_phase[31:30];
            r_sw[0]  <= w_sw;
            for (int k = 1; k <= 9; k++) begin
                r_q[k]  <= r_q[k-1];
                r_sw[k] <= r_sw[k-1];
            end
            r_x[1]   <= w_x;
            for (int k = 2; k <= 8; k++) r_x[k] <= r_x[k-1];
            r_x2p    <= w_x * w_x;
            r_x2[2]  <= w_x2;
            for (int k = 3; k <= 6; k++) r_x2[k] <= r_x2[k-1];
            r_as[2]  <= (w_x2 >> 3) * M_DIV9;
            r_ac[2]  <= (w_x2 >> 3) * M_DIV7;
            r_as[3]  <= r_x2[2] * w_ts3;
            r_ac[3]  <= r_x2[2] * w_tc3;
            r_as[4]  <= 32'(r_as[3] >> 31) * M_DIV21;
            r_ac[4]  <= 32'(r_ac[3] >> 31) * M_DIV15;
            r_as[5]  <= r_x2[4] * w_ts5;
            r_ac[5]  <= r_x2[4] * w_tc5;
            r_as[6]  <= 32'(r_as[5] >> 32) * M_DIV5;
            r_ac[6]  <= 32'(r_ac[5] >> 32) * M_DIV3;
            r_as[7]  <= r_x2[6] * w_ts7;
            r_ac[7]  <= r_x2[6] * w_tc7;
            r_as[8]  <= 32'(r_as[7] >> 31) * M_DIV3;
            r_ac[8]  <= 64'(Q30_ONE - 32'(r_ac[7] >> 31));
            r_as[9]  <= r_x[8] * w_ts9;
            r_ac[9]  <= r_ac[8];
            r_sin    <= n_sin;
            r_cos    <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== rtl/uvs_checker.sv =====
// Port-level checks of the vertex generator, bound to the top level.
module uvs_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_pos_x,
    input logic signed [15:0] o_pos_y,
    input logic signed [15:0] o_pos_z,
    input logic [16:0]        o_tex_u,
    input logic [16:0]        o_tex_v,
    input logic               o_in_range,
    input logic               o_last_of_run
);

    // Stalled result keeps its position and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_pos_z) && $stable(o_last_of_run))
        else $error("output changed while stalled");

    // Rejected request gives a single cleared result
    a_bad_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_range |-> o_last_of_run && o_pos_x == 16'sd0
            && o_pos_y == 16'sd0 && o_pos_z == 16'sd0 && o_tex_u == 17'd0
            && o_tex_v == 17'd0)
        else $error("out-of-range result not cleared");

    // Texture coordinates never exceed one
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_tex_u <= 17'd65536 && o_tex_v <= 17'd65536)
        else $error("texture coordinate above one");

    // Height stays on the unit sphere
    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pos_y <= 16'sd16384 && o_pos_y >= -16'sd16384)
        else $error("height out of range");

endmodule

bind uv_sphere_strip_vertex_gen uvs_port_checks u_uvs_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pos_x       (o_pos_x),
    .o_pos_y       (o_pos_y),
    .o_pos_z       (o_pos_z),
    .o_tex_u       (o_tex_u),
    .o_tex_v       (o_tex_v),
    .o_in_range    (o_in_range),
    .o_last_of_run (o_last_of_run)
);

// ===== tb/uvs_checker.sv =====
// Checker of the UV sphere strip vertex generator: predicts vertices and compares them.
module uvs_checker
    import uvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_ring,
    input  logic [8:0]         i_column,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    input  logic [16:0]        i_tex_u,
    input  logic [16:0]        i_tex_v,
    input  logic               i_in_range,
    input  logic               i_last_of_run,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic [16:0] tu;
        logic [16:0] tv;
        logic        inr;
        logic        last;
    } t_vertex;

    localparam logic [63:0] ONE30 = 64'd1 << 30;

    t_vertex     vertex_q[$];
    logic [8:0]  rings_reg;
    logic [8:0]  segs_reg;

    // Sine/cosine of a 32-bit turn phase, Q2.30 signed
    task automatic phase_sincos(input logic [31:0] p, output longint s, output longint c);
        logic [1:0]  q;
        logic [31:0] r;
        logic        swp;
        logic [63:0] x, x2, t, sm, cm, tmp;
        q   = p[31:30];
        r   = {2'b0, p[29:0]};
        swp = r > (32'd1 << 29);
        if (swp) r = (32'd1 << 30) - r;
        x  = (64'(r) * 64'd3373259426 + (64'd1 << 30)) >> 31;
        x2 = (x * x) >> 30;
        t  = ONE30 - x2 / 72;
        t  = ONE30 - ((x2 * t) >> 30) / 42;
        t  = ONE30 - ((x2 * t) >> 30) / 20;
        t  = ONE30 - ((x2 * t) >> 30) / 6;
        sm = (x * t) >> 30;
        t  = ONE30 - x2 / 56;
        t  = ONE30 - ((x2 * t) >> 30) / 30;
        t  = ONE30 - ((x2 * t) >> 30) / 12;
        cm = ONE30 - ((x2 * t) >> 30) / 2;
        if (swp) begin
            tmp = sm; sm = cm; cm = tmp;
        end
        case (q)
            2'd0: begin s = sm;  c = cm;  end
            2'd1: begin s = cm;  c = -longint'(sm); end
            2'd2: begin s = -longint'(sm); c = -longint'(cm); end
            default: begin s = -longint'(cm); c = sm; end
        endcase
    endtask

    function automatic longint scale_product(input longint a, input longint b);
        logic [63:0] m;
        m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (64'd1 << 45)) >> 46;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [16:0] tex_frac(input logic [31:0] n, input logic [31:0] d);
        return 17'(((64'(n) << 16) + d / 2) / d);
    endfunction

    task automatic push_vertex(input int a, input int j, input int rn, input int sn,
                               input logic last);
        t_vertex     v;
        logic [31:0] pl, pg;
        longint      sl, cl, sg, cg, m;
        pl = 32'(((64'(a) << 31) + rn / 2) / rn);
        pg = 32'(((64'(j) << 32) + sn / 2) / sn);
        phase_sincos(pl, sl, cl);
        phase_sincos(pg, sg, cg);
        v.px = 16'(scale_product(-cg, sl));
        m    = ((cl < 0 ? -cl : cl) + (64'd1 << 15)) >>> 16;
        // height is -cos of the latitude phase
        v.py = 16'(cl < 0 ? m : -m);
        v.pz = 16'(scale_product(sg, sl));
        v.tu = tex_frac(j, sn);
        v.tv = tex_frac(a, rn);
        v.inr  = 1'b1;
        v.last = last;
        vertex_q.push_back(v);
    endtask

    // Expand one request into its strip vertices
    task automatic predict_request(input int ring, input int col);
        int rn, sn;
        rn = rings_reg > 256 ? 256 : rings_reg;
        sn = segs_reg > 256 ? 256 : segs_reg;
        if (rn == 0 || sn == 0 || ring >= rn || col > sn) begin
            vertex_q.push_back('{default: '0, last: 1'b1});
        end else begin
            if (ring > 0 && col == 0) begin
                push_vertex(ring - 1, sn, rn, sn, 1'b0);
                push_vertex(ring + 1, 0, rn, sn, 1'b0);
            end
            push_vertex(ring + 1, col, rn, sn, 1'b0);
            push_vertex(ring, col, rn, sn, 1'b1);
        end
    endtask

    // Watch channels at the rising edge
    always @(posedge i_clk) begin
        t_vertex e, g;
        if (!i_rst_n) begin
            rings_reg    <= RING_COUNT_RST;
            segs_reg     <= SEGMENT_COUNT_RST;
            o_fail_count <= 0;
            vertex_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_RING_COUNT) rings_reg <= i_cfg_data;
                else segs_reg <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) predict_request(i_ring, i_column);
            if (i_out_valid && i_out_ready) begin
                g = {i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v, i_in_range, i_last_of_run};
                if (vertex_q.size() == 0) begin
                    $display("%0t: unexpected vertex %h", $realtime, g);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = vertex_q.pop_front();
                    if (e !== g) begin
                        $display("%0t: vertex mismatch x %0d/%0d y %0d/%0d z %0d/%0d",
                                 $realtime, $signed(e.px), i_pos_x, $signed(e.py), i_pos_y,
                                 $signed(e.pz), i_pos_z);
                        $display("    u %0d/%0d v %0d/%0d in_range %b/%b last %b/%b",
                                 e.tu, i_tex_u, e.tv, i_tex_v, e.inr, i_in_range,
                                 e.last, i_last_of_run);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= vertex_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives requests and configuration, and reports the verdict.
module testbench;
    import uvs_pkg::*;

    logic               i_clk = 0, i_rst_n = 0;
    logic               cfg_valid = 0, cfg_ready, cfg_index = CFG_RING_COUNT;
    logic [8:0]         cfg_data = '0;
    logic               in_valid = 0, in_ready;
    logic [7:0]         ring = '0;
    logic [8:0]         column = '0;
    logic               out_valid, out_ready = 0;
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic [16:0]        tex_u, tex_v;
    logic               in_range, last_of_run;
    int                 fail_count, pending, idle_cycles;
    logic               calm = 0;
    int                 rc = 16, sc = 32;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    uv_sphere_strip_vertex_gen dut (
        .i_clk, .i_rst_n,
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_ring(ring), .i_column(column), .o_out_valid(out_valid),
        .i_out_ready(out_ready), .o_pos_x(pos_x), .o_pos_y(pos_y), .o_pos_z(pos_z),
        .o_tex_u(tex_u), .o_tex_v(tex_v), .o_in_range(in_range),
        .o_last_of_run(last_of_run)
    );

    uvs_checker chk (
        .i_clk, .i_rst_n,
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_ring(ring), .i_column(column), .i_out_valid(out_valid),
        .i_out_ready(out_ready), .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_tex_u(tex_u), .i_tex_v(tex_v), .i_in_range(in_range),
        .i_last_of_run(last_of_run), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stalls in bursts
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (calm) out_ready = 1;
            else if ($urandom_range(0, 3) == 0) begin
                out_ready = 0;
                n = $urandom_range(1, 11);
                repeat (n - 1) @(negedge i_clk);
            end else out_ready = 1;
        end
    end

    // Watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= 5000) begin
            $display("** uv_sphere_strip_vertex_gen: FAILED **");
            $finish;
        end else idle_cycles <= idle_cycles + 1;
    end

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int val);
        cfg_index = idx;
        cfg_data  = 9'(val);
        cfg_valid = 1;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 0;
        if (idx == CFG_RING_COUNT) rc = val; else sc = val;
    endtask

    task automatic send_request(input int r, input int c);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            repeat (n) @(negedge i_clk);
        end
        ring      = 8'(r);
        column    = 9'(c);
        in_valid  = 1;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        in_valid = 0;
    endtask

    // Mostly valid requests; some out of range
    task automatic random_phase(input int count);
        int rmax, cmax;
        for (int k = 0; k < count; k++) begin
            rmax = rc > 256 ? 256 : rc;
            cmax = sc > 256 ? 256 : sc;
            if ($urandom_range(0, 7) == 0 || rmax == 0 || cmax == 0)
                send_request($urandom_range(0, 255), $urandom_range(0, 511));
            else if ($urandom_range(0, 3) == 0)
                send_request($urandom_range(0, rmax - 1), 0);
            else
                send_request($urandom_range(0, rmax - 1), $urandom_range(0, cmax));
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;
        // Directed: reset counts, stitch, extremes, out of range
        send_request(0, 0);
        send_request(1, 0);
        send_request(15, 32);
        send_request(15, 0);
        send_request(16, 0);
        send_request(0, 33);
        send_request(255, 511);
        send_request(7, 13);
        wait_drained();
        write_reg(CFG_RING_COUNT, 256);
        write_reg(CFG_SEGMENT_COUNT, 256);
        send_request(255, 256);
        send_request(255, 0);
        send_request(128, 170);
        send_request(0, 257);
        wait_drained();
        write_reg(CFG_RING_COUNT, 1);
        write_reg(CFG_SEGMENT_COUNT, 1);
        send_request(0, 0);
        send_request(0, 1);
        send_request(1, 1);
        wait_drained();
        write_reg(CFG_RING_COUNT, 0);
        send_request(0, 0);
        wait_drained();
        write_reg(CFG_RING_COUNT, 511);
        write_reg(CFG_SEGMENT_COUNT, 0);
        send_request(3, 0);
        wait_drained();
        write_reg(CFG_SEGMENT_COUNT, 300);
        send_request(200, 256);
        send_request(170, 0);
        wait_drained();
        // Random phases over several settings
        write_reg(CFG_RING_COUNT, $urandom_range(2, 40));
        write_reg(CFG_SEGMENT_COUNT, $urandom_range(3, 64));
        random_phase(60);
        wait_drained();
        write_reg(CFG_RING_COUNT, $urandom_range(1, 511));
        write_reg(CFG_SEGMENT_COUNT, $urandom_range(1, 511));
        random_phase(60);
        wait_drained();
        write_reg(CFG_RING_COUNT, 16);
        write_reg(CFG_SEGMENT_COUNT, $urandom_range(3, 256));
        random_phase(50);
        calm = 1;
        random_phase(40);
        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("** uv_sphere_strip_vertex_gen: PASSED **");
        else
            $display("** uv_sphere_strip_vertex_gen: FAILED **");
        $finish;
    end

endmodule

// ===== uv_sphere_strip_vertex_gen.f =====
rtl/uvs_pkg.sv
rtl/uvs_sincos.sv
rtl/uv_sphere_strip_vertex_gen.sv
rtl/uvs_checker.sv
tb/uvs_checker.sv
tb/testbench.sv
